@@ rtl/core/hash_chain_random_byte_generator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hash chain random byte generator
// Concurrent checks that are clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef HASH_CHAIN_RANDOM_BYTE_GENERATOR_TOP_ASSERT_SVH
`define HASH_CHAIN_RANDOM_BYTE_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCRBG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hcrbg check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCRBG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hcrbg check failed");

`endif

@@ rtl/core/hcrbg_pkg.sv @@
// ----------------------------------------------------------------------------
// hcrbg_pkg
// Shared types, constants and codes of the hash chain random byte generator.
// ----------------------------------------------------------------------------
package hcrbg_pkg;

    localparam int BLOCK_BYTES = 20;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int INDEX_W     = $clog2(BLOCK_BYTES + 1);
    localparam int SENT_W      = 17;
    localparam int LIMIT_W     = 16;
    localparam int SHA_ROUNDS  = 80;
    localparam int ROUND_W     = $clog2(SHA_ROUNDS);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

    localparam logic [31:0] SHA_K0 = 32'h5A827999;
    localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

    // Byte 0 sits at the most significant end, as it is the first byte hashed.
    typedef logic [0:BLOCK_BYTES-1][7:0] t_block;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_SEED    = 2'd1,
        OP_REKEY   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH_BT,
        S_LOAD_KEY,
        S_HASH_KEY,
        S_HASH_IDX,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SHA_IDLE,
        SHA_ROUND,
        SHA_DONE
    } t_sha_state;

    typedef struct packed {
        logic start;
        logic long_msg;
    } t_sha_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sha_rsp;

endpackage

@@ rtl/core/hcrbg_if.sv @@
// ----------------------------------------------------------------------------
// hcrbg_if
// Valid/ready channels carrying requests into and bytes out of the generator.
// ----------------------------------------------------------------------------
interface hcrbg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] seed_byte;

    modport source (output valid, output operation, output seed_byte, input ready);
    modport sink   (input valid, input operation, input seed_byte, output ready);
endinterface

interface hcrbg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

@@ rtl/core/hash_chain_random_byte_generator_top.sv @@
// ----------------------------------------------------------------------------
// hash_chain_random_byte_generator_top
// SHA-1 hash chain that hands out random bytes one request at a time.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload                       Handshake
// i_in      in         operation[1:0], seed_byte[7:0] valid/ready
// o_out     out        random_byte[7:0]               valid/ready
// i_cfg     in         i_cfg_data[15:0] (limit)       i_cfg_we, no wait
//
// A seed shift is taken without leaving the idle state, and a byte request that
// needs no hashing goes through the emit state alone. One SHA-1 pass runs 80
// rounds and then a done state; a request that crosses a block boundary and a
// seed rekey each take one pass, and a backtrack rekey runs two passes.
// Reset is synchronous and active low; it clears all three blocks and both
// counters and sets the limit to 500. A byte waiting on o_out leaves the input
// open for one more request, whose byte then holds the input until o_out frees.
//
module hash_chain_random_byte_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcrbg_in_if.sink    i_in,
    hcrbg_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    hcrbg_pkg::t_state r_state, n_state;

    hcrbg_pkg::t_block r_key, n_key;
    hcrbg_pkg::t_block r_outblk, n_outblk;
    hcrbg_pkg::t_block r_seed, n_seed;
    logic [hcrbg_pkg::INDEX_W-1:0] r_index, n_index;
    logic [hcrbg_pkg::SENT_W-1:0]  r_sent, n_sent;
    logic [hcrbg_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic r_emit, n_emit;
    logic r_out_valid, n_out_valid;
    logic [7:0] r_byte, n_byte;

    hcrbg_pkg::t_sha_req sha_req;
    hcrbg_pkg::t_sha_rsp sha_rsp;
    hcrbg_pkg::t_block   digest;

    logic accept;
    logic out_free;
    logic need_bt;
    logic need_idx;
    hcrbg_pkg::t_op op;

    assign op       = hcrbg_pkg::t_op'(i_in.operation);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // The backtrack check compares against the limit widened by one bit, since
    // the sent count may run one past it.
    assign need_bt  = (r_sent > {1'b0, r_limit});
    assign need_idx = (r_index >= hcrbg_pkg::INDEX_W'(hcrbg_pkg::BLOCK_BYTES));

    hcrbg_sha1 u_sha1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (sha_req),
        .i_key    (r_key),
        .i_out    (r_outblk),
        .o_rsp    (sha_rsp),
        .o_digest (digest)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcrbg_pkg::S_IDLE: begin
                if (accept) begin
                    case (op)
                        hcrbg_pkg::OP_REQUEST: begin
                            if (need_bt) begin
                                n_state = hcrbg_pkg::S_HASH_BT;
                            end else if (need_idx) begin
                                n_state = hcrbg_pkg::S_HASH_IDX;
                            end else begin
                                n_state = hcrbg_pkg::S_EMIT;
                            end
                        end
                        hcrbg_pkg::OP_REKEY: begin
                            n_state = hcrbg_pkg::S_LOAD_KEY;
                        end
                        default: begin
                            n_state = hcrbg_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hcrbg_pkg::S_HASH_BT: begin
                if (sha_rsp.done) begin
                    n_state = hcrbg_pkg::S_LOAD_KEY;
                end
            end
            hcrbg_pkg::S_LOAD_KEY: begin
                n_state = hcrbg_pkg::S_HASH_KEY;
            end
            hcrbg_pkg::S_HASH_KEY: begin
                if (sha_rsp.done) begin
                    n_state = r_emit ? hcrbg_pkg::S_EMIT : hcrbg_pkg::S_IDLE;
                end
            end
            hcrbg_pkg::S_HASH_IDX: begin
                if (sha_rsp.done) begin
                    n_state = hcrbg_pkg::S_EMIT;
                end
            end
            hcrbg_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = hcrbg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hcrbg_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and the hash unit's start. Long passes
    // hash key followed by output and start straight from the request; the
    // rekey pass hashes the key alone once the new key has been stored.
    always_comb begin
        i_in.ready       = (r_state == hcrbg_pkg::S_IDLE);
        sha_req.start    = 1'b0;
        sha_req.long_msg = 1'b0;
        unique case (r_state)
            hcrbg_pkg::S_IDLE: begin
                if (accept && op == hcrbg_pkg::OP_REQUEST && (need_bt || need_idx)) begin
                    sha_req.start    = 1'b1;
                    sha_req.long_msg = 1'b1;
                end
            end
            hcrbg_pkg::S_LOAD_KEY: begin
                sha_req.start = 1'b1;
            end
            default: begin
                sha_req.start = 1'b0;
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.random_byte = r_byte;

    // Datapath updates.
    always_comb begin
        n_key       = r_key;
        n_outblk    = r_outblk;
        n_seed      = r_seed;
        n_index     = r_index;
        n_sent      = r_sent;
        n_limit     = r_limit;
        n_emit      = r_emit;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;

        if (i_cfg_we) begin
            n_limit = i_cfg_data;
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            hcrbg_pkg::S_IDLE: begin
                if (accept) begin
                    n_emit = (op == hcrbg_pkg::OP_REQUEST);
                    if (op == hcrbg_pkg::OP_SEED) begin
                        // Older bytes move toward byte 0; the new byte enters last.
                        n_seed = {r_seed[1:hcrbg_pkg::BLOCK_BYTES-1], i_in.seed_byte};
                    end else if (op == hcrbg_pkg::OP_REKEY) begin
                        n_key = r_seed;
                    end
                end
            end
            hcrbg_pkg::S_HASH_BT: begin
                if (sha_rsp.done) begin
                    n_outblk = digest;
                    n_key    = digest;
                end
            end
            hcrbg_pkg::S_HASH_KEY: begin
                if (sha_rsp.done) begin
                    n_outblk = digest;
                    n_index  = '0;
                    n_sent   = '0;
                end
            end
            hcrbg_pkg::S_HASH_IDX: begin
                if (sha_rsp.done) begin
                    n_outblk = digest;
                    n_index  = '0;
                end
            end
            hcrbg_pkg::S_EMIT: begin
                if (out_free) begin
                    n_byte      = r_outblk[r_index];
                    n_out_valid = 1'b1;
                    n_index     = r_index + 1'b1;
                    n_sent      = r_sent + 1'b1;
                end
            end
            default: begin
                n_emit = r_emit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcrbg_pkg::S_IDLE;
            r_key       <= '0;
            r_outblk    <= '0;
            r_seed      <= '0;
            r_index     <= '0;
            r_sent      <= '0;
            r_limit     <= hcrbg_pkg::LIMIT_RESET;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_outblk    <= n_outblk;
            r_seed      <= n_seed;
            r_index     <= n_index;
            r_sent      <= n_sent;
            r_limit     <= n_limit;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

`include "hash_chain_random_byte_generator_top_assert.svh"

    // The hash unit is only started when it has finished the previous pass.
    `HCRBG_ASSERT_NOW(a_sha_start_idle, sha_req.start, !sha_rsp.busy)
    // A byte is only picked from inside the output block.
    `HCRBG_ASSERT_NOW(a_emit_index, r_state == hcrbg_pkg::S_EMIT,
        r_index < hcrbg_pkg::INDEX_W'(hcrbg_pkg::BLOCK_BYTES))
    // A completed rekey pass leaves both counters clear.
    `HCRBG_ASSERT_NEXT(a_rekey_clears, r_state == hcrbg_pkg::S_HASH_KEY && sha_rsp.done,
        r_index == '0 && r_sent == '0)
    // Emitting a byte always presents it on the output.
    `HCRBG_ASSERT_NEXT(a_emit_shows, r_state == hcrbg_pkg::S_EMIT && out_free,
        r_out_valid && r_state == hcrbg_pkg::S_IDLE)

endmodule

@@ rtl/core/hcrbg_sha1.sv @@
// ----------------------------------------------------------------------------
// hcrbg_sha1
// Iterative SHA-1 over one padded block, one round per clock cycle.
// ----------------------------------------------------------------------------
module hcrbg_sha1 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcrbg_pkg::t_sha_req i_req,
    input  hcrbg_pkg::t_block   i_key,
    input  hcrbg_pkg::t_block   i_out,
    output hcrbg_pkg::t_sha_rsp o_rsp,
    output hcrbg_pkg::t_block   o_digest
);

    hcrbg_pkg::t_sha_state r_state, n_state;
    logic [hcrbg_pkg::ROUND_W-1:0] r_round, n_round;
    logic [0:15][31:0] r_w, n_w;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [511:0] msg;
    logic [31:0] f, k, t, w_new;

    // A long message is key followed by output (40 bytes), a short one the key alone.
    always_comb begin
        if (i_req.long_msg) begin
            msg = {i_key, i_out, 8'h80, 168'd0, 16'd320};
        end else begin
            msg = {i_key, 8'h80, 328'd0, 16'd160};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcrbg_pkg::SHA_IDLE: begin
                if (i_req.start) begin
                    n_state = hcrbg_pkg::SHA_ROUND;
                end
            end
            hcrbg_pkg::SHA_ROUND: begin
                if (r_round == hcrbg_pkg::ROUND_W'(hcrbg_pkg::SHA_ROUNDS - 1)) begin
                    n_state = hcrbg_pkg::SHA_DONE;
                end
            end
            hcrbg_pkg::SHA_DONE: begin
                n_state = hcrbg_pkg::SHA_IDLE;
            end
            default: begin
                n_state = hcrbg_pkg::SHA_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rsp.busy = (r_state != hcrbg_pkg::SHA_IDLE);
        o_rsp.done = (r_state == hcrbg_pkg::SHA_DONE);
        o_digest   = {r_a + hcrbg_pkg::SHA_H0, r_b + hcrbg_pkg::SHA_H1,
                      r_c + hcrbg_pkg::SHA_H2, r_d + hcrbg_pkg::SHA_H3,
                      r_e + hcrbg_pkg::SHA_H4};
    end

    always_comb begin
        if (r_round < hcrbg_pkg::ROUND_W'(20)) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = hcrbg_pkg::SHA_K0;
        end else if (r_round < hcrbg_pkg::ROUND_W'(40)) begin
            f = r_b ^ r_c ^ r_d;
            k = hcrbg_pkg::SHA_K1;
        end else if (r_round < hcrbg_pkg::ROUND_W'(60)) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = hcrbg_pkg::SHA_K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = hcrbg_pkg::SHA_K3;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        // The window holds w[t] .. w[t+15]; this forms the XOR that, rotated left by one, gives w[t+16].
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    end

    always_comb begin
        n_round = r_round;
        n_w = r_w;
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        n_e = r_e;
        if (r_state == hcrbg_pkg::SHA_IDLE && i_req.start) begin
            n_round = '0;
            n_w = msg;
            n_a = hcrbg_pkg::SHA_H0;
            n_b = hcrbg_pkg::SHA_H1;
            n_c = hcrbg_pkg::SHA_H2;
            n_d = hcrbg_pkg::SHA_H3;
            n_e = hcrbg_pkg::SHA_H4;
        end else if (r_state == hcrbg_pkg::SHA_ROUND) begin
            n_round = r_round + 1'b1;
            n_w = {r_w[1:15], w_new[30:0], w_new[31]};
            n_a = t;
            n_b = r_a;
            n_c = {r_b[1:0], r_b[31:2]};
            n_d = r_c;
            n_e = r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcrbg_pkg::SHA_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
    end

endmodule
